FILE: design/grid_weighted_draw_without_replacement_core_assert.svh
// Assertion macros used by the grid weighted draw datapath.
`ifndef GRID_WEIGHTED_DRAW_WITHOUT_REPLACEMENT_CORE_ASSERT_SVH
`define GRID_WEIGHTED_DRAW_WITHOUT_REPLACEMENT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GWD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/gwd_pkg.sv
// Types, constants and helper functions of the grid weighted draw block.
package gwd_pkg;

    localparam int GRID_ROWS = 8;
    localparam int GRID_COLS = 32;
    localparam int CELLS     = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int ROW_W     = 3;
    localparam int COL_W     = 5;
    localparam int SPREAD_W  = 5;
    localparam int WGT_W     = 11;
    localparam int TOT_W     = 19;
    localparam int SUM_W     = 20;
    localparam int PICK_W    = 19;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;
    localparam logic [SUM_W-1:0] TOT_MAX = SUM_W'(524287);

    typedef enum logic [1:0] {
        CMD_REGISTER = 2'd0,
        CMD_START    = 2'd1,
        CMD_DRAW     = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_DRAWN    = 2'd1,
        STAT_NO_WGT   = 2'd2,
        STAT_BAD_PICK = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_SPREAD_X = 2'd0,
        CFG_SPREAD_Y = 2'd1,
        CFG_ROWS     = 2'd2,
        CFG_COLS     = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_BOOT,
        ST_IDLE,
        ST_SETUP,
        ST_WRITE,
        ST_CLEAR,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic wr_init;
        logic wr_step;
        logic clr_step;
        logic scan_init;
        logic scan_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic wr_last;
        logic clr_last;
        logic scan_last;
        logic out_busy;
    } dp_status_t;

    // Index of the last row in use; zero counts as one row, large values clamp.
    function automatic logic [ROW_W-1:0] last_row(input logic [3:0] rows);
        logic [ROW_W-1:0] res;
        if (rows == 4'd0) begin
            res = '0;
        end else if (rows > 4'(GRID_ROWS)) begin
            res = ROW_W'(GRID_ROWS - 1);
        end else begin
            res = ROW_W'(rows - 4'd1);
        end
        return res;
    endfunction

    function automatic logic [COL_W-1:0] last_col(input logic [5:0] cols);
        logic [COL_W-1:0] res;
        if (cols == 6'd0) begin
            res = '0;
        end else if (cols > 6'(GRID_COLS)) begin
            res = COL_W'(GRID_COLS - 1);
        end else begin
            res = COL_W'(cols - 6'd1);
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * GRID_COLS + int'(col));
    endfunction

endpackage

FILE: design/grid_weighted_draw_without_replacement_core.sv
// Top level of the grid weighted draw without replacement core.
// Keeps an 8 x 32 grid of 11-bit weights with a drawn mark per cell. Every item,
// whatever its command, ends with one scan over the rows and columns in use, one
// cell a cycle through the weight memory's single read port, which yields the
// remaining total; a draw picks its cell in the same scan. After the scan a drain
// state lets the last read be summed, and the result is registered on leaving the
// finish state once the output is free. A registration first writes each window
// cell in the area through the memory's single write port. A start item first
// clears all 256 drawn marks one per cycle, and the same clearing pass runs after
// reset before the first item is accepted. The next item is taken while a result
// still waits on the output; a further result waits until that one is taken.
// Configuration writes are always accepted.
module grid_weighted_draw_without_replacement_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // band_row[2:0], band_col[7:3], pick[26:8], zero fill
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // drawn_row[2:0], drawn_col[7:3], remaining_total[26:8], zero
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    gwd_pkg::ctrl_cmd_t  cmd;
    gwd_pkg::dp_status_t dp_stat;

    logic [gwd_pkg::ROW_W-1:0] out_row;
    logic [gwd_pkg::COL_W-1:0] out_col;
    logic [gwd_pkg::TOT_W-1:0] out_total;

    assign cfg_ready = 1'b1;

    gwd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_register (s_tuser == gwd_pkg::CMD_REGISTER),
        .in_start    (s_tuser == gwd_pkg::CMD_START),
        .in_ready    (s_tready),
        .dp_stat     (dp_stat),
        .cmd         (cmd)
    );

    gwd_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .dp_stat    (dp_stat),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_command (s_tuser),
        .in_row     (s_tdata[2:0]),
        .in_col     (s_tdata[7:3]),
        .in_pick    (s_tdata[26:8]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_total  (out_total)
    );

    assign m_tdata = {5'd0, out_total, out_col, out_row};

endmodule

FILE: design/gwd_ram.sv
// Generic single write port, single read port RAM with registered read data.
module gwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/gwd_ctrl.sv
// Controller state machine sequencing window writes, the grid scan and the result.
module gwd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  logic                   in_register,
    input  logic                   in_start,
    output logic                   in_ready,
    input  gwd_pkg::dp_status_t    dp_stat,
    output gwd_pkg::ctrl_cmd_t     cmd
);

    gwd_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gwd_pkg::ST_BOOT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gwd_pkg::ST_BOOT: begin
                if (dp_stat.clr_last) begin
                    state_next = gwd_pkg::ST_IDLE;
                end
            end
            gwd_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (in_register) begin
                        state_next = gwd_pkg::ST_SETUP;
                    end else if (in_start) begin
                        state_next = gwd_pkg::ST_CLEAR;
                    end else begin
                        state_next = gwd_pkg::ST_SCAN;
                    end
                end
            end
            gwd_pkg::ST_SETUP:  state_next = gwd_pkg::ST_WRITE;
            gwd_pkg::ST_WRITE: begin
                if (dp_stat.wr_last) begin
                    state_next = gwd_pkg::ST_SCAN;
                end
            end
            gwd_pkg::ST_CLEAR: begin
                if (dp_stat.clr_last) begin
                    state_next = gwd_pkg::ST_SCAN;
                end
            end
            gwd_pkg::ST_SCAN: begin
                if (dp_stat.scan_last) begin
                    state_next = gwd_pkg::ST_DRAIN;
                end
            end
            gwd_pkg::ST_DRAIN:  state_next = gwd_pkg::ST_FINISH;
            gwd_pkg::ST_FINISH: begin
                if (!dp_stat.out_busy) begin
                    state_next = gwd_pkg::ST_IDLE;
                end
            end
            default:            state_next = gwd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            gwd_pkg::ST_BOOT:   cmd.clr_step = 1'b1;
            gwd_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            gwd_pkg::ST_SETUP:  cmd.wr_init = 1'b1;
            gwd_pkg::ST_WRITE: begin
                cmd.wr_step   = 1'b1;
                cmd.scan_init = dp_stat.wr_last;
            end
            gwd_pkg::ST_CLEAR: begin
                cmd.clr_step  = 1'b1;
                cmd.scan_init = dp_stat.clr_last;
            end
            gwd_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
            gwd_pkg::ST_DRAIN:  cmd = '0;
            gwd_pkg::ST_FINISH: cmd.finish = !dp_stat.out_busy;
            default:            cmd = '0;
        endcase
    end

endmodule

FILE: design/gwd_datapath.sv
// Datapath: configuration, weight memory, drawn marks, scan accumulator and result.
`include "grid_weighted_draw_without_replacement_core_assert.svh"

module gwd_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  gwd_pkg::ctrl_cmd_t                cmd,
    output gwd_pkg::dp_status_t               dp_stat,
    input  logic                              cfg_valid,
    input  logic [gwd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gwd_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic [1:0]                        in_command,
    input  logic [gwd_pkg::ROW_W-1:0]         in_row,
    input  logic [gwd_pkg::COL_W-1:0]         in_col,
    input  logic [gwd_pkg::PICK_W-1:0]        in_pick,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        out_status,
    output logic [gwd_pkg::ROW_W-1:0]         out_row,
    output logic [gwd_pkg::COL_W-1:0]         out_col,
    output logic [gwd_pkg::TOT_W-1:0]         out_total
);

    localparam int AW = gwd_pkg::ADDR_W;
    localparam int RW = gwd_pkg::ROW_W;
    localparam int CW = gwd_pkg::COL_W;
    localparam int SW = gwd_pkg::SPREAD_W;
    localparam int WW = gwd_pkg::WGT_W;
    localparam int NW = gwd_pkg::SUM_W;

    logic wr_last, clr_last, scan_last, out_busy;

    assign dp_stat = '{wr_last: wr_last, clr_last: clr_last, scan_last: scan_last,
                       out_busy: out_busy};

    // Configuration registers.
    logic [SW-1:0] sx_reg, sy_reg;
    logic [3:0]    rows_reg;
    logic [5:0]    cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx_reg   <= SW'(16);
            sy_reg   <= SW'(4);
            rows_reg <= 4'd8;
            cols_reg <= 6'd32;
        end else if (cfg_valid) begin
            case (cfg_index)
                gwd_pkg::CFG_SPREAD_X: sx_reg   <= cfg_data[SW-1:0];
                gwd_pkg::CFG_SPREAD_Y: sy_reg   <= cfg_data[SW-1:0];
                gwd_pkg::CFG_ROWS:     rows_reg <= cfg_data[3:0];
                gwd_pkg::CFG_COLS:     cols_reg <= cfg_data;
                default:               sx_reg   <= sx_reg;
            endcase
        end
    end

    logic [RW-1:0] lastr;
    logic [CW-1:0] lastc;
    assign lastr = gwd_pkg::last_row(rows_reg);
    assign lastc = gwd_pkg::last_col(cols_reg);

    // Item registers.
    logic [1:0]                 op_reg;
    logic [RW-1:0]              row_reg;
    logic [CW-1:0]              col_reg;
    logic [gwd_pkg::PICK_W-1:0] pick_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_command;
            row_reg  <= in_row;
            col_reg  <= in_col;
            pick_reg <= in_pick;
        end
    end

    // Registration window, clamped to the area in use.
    logic [CW-1:0] cmin, cmax;
    logic [RW-1:0] rmin, rmax;
    logic [5:0]    csum, rsum;
    logic          win_empty;

    always_comb begin
        csum = 6'(col_reg) + 6'(sx_reg);
        rsum = 6'(row_reg) + 6'(sy_reg);
        cmin = (col_reg >= sx_reg) ? CW'(col_reg - sx_reg) : '0;
        cmax = (csum > 6'(lastc)) ? lastc : CW'(csum);
        rmin = (SW'(row_reg) >= sy_reg) ? RW'(SW'(row_reg) - sy_reg) : '0;
        rmax = (rsum > 6'(lastr)) ? lastr : RW'(rsum);
        // A band beyond the area can still reach into it with a wide window.
        win_empty = (cmin > cmax) || (rmin > rmax);
    end

    logic [RW-1:0] wy_reg, wy_next;
    logic [CW-1:0] wx_reg, wx_next;
    logic          wr_en;
    logic [CW-1:0] dx;
    logic [RW-1:0] dy;
    logic [11:0]   wcalc;
    logic [WW-1:0] wdata;

    always_comb begin
        dx    = (wx_reg >= col_reg) ? (wx_reg - col_reg) : (col_reg - wx_reg);
        dy    = (wy_reg >= row_reg) ? (wy_reg - row_reg) : (row_reg - wy_reg);
        wcalc = 12'(10'(sx_reg) * 10'(sx_reg)) + 12'(10'(sy_reg) * 10'(sy_reg))
              - 12'(10'(dx) * 10'(dx)) - 12'(6'(dy) * 6'(dy));
        wdata = wcalc[WW-1:0];
        wr_en = cmd.wr_step && !win_empty;
        wr_last = win_empty || (wx_reg == cmax && wy_reg == rmax);
        wy_next = wy_reg;
        wx_next = wx_reg;
        if (cmd.wr_init) begin
            wy_next = rmin;
            wx_next = cmin;
        end else if (wr_en) begin
            if (wx_reg == cmax) begin
                wx_next = cmin;
                wy_next = wy_reg + RW'(1);
            end else begin
                wx_next = wx_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        wy_reg <= wy_next;
        wx_reg <= wx_next;
    end

    // Clearing pass over the drawn marks, after reset and for each start item.
    logic [AW-1:0] clr_reg, clr_next;

    assign clr_next = cmd.clr_step ? clr_reg + AW'(1) : clr_reg;
    assign clr_last = (clr_reg == AW'(gwd_pkg::CELLS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else begin
            clr_reg <= clr_next;
        end
    end

    // Scan address counters.
    logic [RW-1:0] sr_reg, sr_next;
    logic [CW-1:0] sc_reg, sc_next;
    logic          scan_clear;

    assign scan_clear = cmd.load || cmd.scan_init;
    assign scan_last  = (sr_reg == lastr) && (sc_reg == lastc);

    always_comb begin
        sr_next = sr_reg;
        sc_next = sc_reg;
        if (scan_clear) begin
            sr_next = '0;
            sc_next = '0;
        end else if (cmd.scan_step) begin
            if (sc_reg == lastc) begin
                sc_next = '0;
                sr_next = sr_reg + RW'(1);
            end else begin
                sc_next = sc_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        sr_reg <= sr_next;
        sc_reg <= sc_next;
    end

    // Weight memory; an entry never written reads as zero through its valid bit.
    logic [WW-1:0]            rdata;
    logic [0:0]               mark_rdata;
    logic [AW-1:0]            waddr;
    logic [gwd_pkg::CELLS-1:0] wv_reg, wv_next;

    assign waddr = gwd_pkg::cell_addr(wy_reg, wx_reg);

    gwd_ram #(
        .WIDTH (WW),
        .DEPTH (gwd_pkg::CELLS)
    ) u_wgt_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.scan_step),
        .raddr (gwd_pkg::cell_addr(sr_reg, sc_reg)),
        .rdata (rdata)
    );

    logic          rd_vld_reg;
    logic [RW-1:0] rd_row_reg;
    logic [CW-1:0] rd_col_reg;
    logic [AW-1:0] rd_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_step;
        end
        rd_row_reg <= sr_reg;
        rd_col_reg <= sc_reg;
    end

    assign rd_addr = gwd_pkg::cell_addr(rd_row_reg, rd_col_reg);

    // Running sum and first cell that reaches the pick.
    logic [NW-1:0] run_reg, run_next;
    logic          found_reg, found_next;
    logic [RW-1:0] frow_reg, frow_next;
    logic [CW-1:0] fcol_reg, fcol_next;
    logic [WW-1:0] fw_reg, fw_next, w_eff;
    logic          undrawn;

    always_comb begin
        w_eff      = wv_reg[rd_addr] ? rdata : '0;
        undrawn    = !mark_rdata[0];
        run_next   = run_reg;
        found_next = found_reg;
        frow_next  = frow_reg;
        fcol_next  = fcol_reg;
        fw_next    = fw_reg;
        if (scan_clear) begin
            run_next   = '0;
            found_next = 1'b0;
        end else if (rd_vld_reg && undrawn) begin
            run_next = run_reg + NW'(w_eff);
            if (!found_reg && run_next >= NW'(pick_reg)) begin
                found_next = 1'b1;
                frow_next  = rd_row_reg;
                fcol_next  = rd_col_reg;
                fw_next    = w_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        run_reg  <= run_next;
        frow_reg <= frow_next;
        fcol_reg <= fcol_next;
        fw_reg   <= fw_next;
    end

    // Result evaluation.
    logic          is_draw, draw_ok;
    logic [1:0]    res_status;
    logic [NW-1:0] res_total;
    logic [gwd_pkg::TOT_W-1:0] res_sat;

    always_comb begin
        is_draw    = (op_reg == gwd_pkg::CMD_DRAW);
        draw_ok    = 1'b0;
        res_status = gwd_pkg::STAT_DONE;
        res_total  = run_reg;
        if (is_draw) begin
            if (run_reg == '0) begin
                res_status = gwd_pkg::STAT_NO_WGT;
            end else if (pick_reg == '0 || NW'(pick_reg) > run_reg) begin
                res_status = gwd_pkg::STAT_BAD_PICK;
            end else begin
                res_status = gwd_pkg::STAT_DRAWN;
                draw_ok    = 1'b1;
                res_total  = run_reg - NW'(fw_reg);
            end
        end
        res_sat = (res_total > gwd_pkg::TOT_MAX) ? gwd_pkg::TOT_MAX[gwd_pkg::TOT_W-1:0]
                                                 : res_total[gwd_pkg::TOT_W-1:0];
    end

    // Drawn marks: cleared by the clearing pass, set for the drawn cell at the result.
    logic          mark_we;
    logic [AW-1:0] mark_waddr;
    logic [0:0]    mark_wdata;

    assign mark_we    = cmd.clr_step || (cmd.finish && draw_ok);
    assign mark_waddr = cmd.clr_step ? clr_reg : gwd_pkg::cell_addr(frow_reg, fcol_reg);
    assign mark_wdata = !cmd.clr_step;

    gwd_ram #(
        .WIDTH (1),
        .DEPTH (gwd_pkg::CELLS)
    ) u_mark_ram (
        .aclk  (aclk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (cmd.scan_step),
        .raddr (gwd_pkg::cell_addr(sr_reg, sc_reg)),
        .rdata (mark_rdata)
    );

    always_comb begin
        wv_next = wv_reg;
        if (wr_en) begin
            wv_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wv_reg <= '0;
        end else begin
            wv_reg <= wv_next;
        end
    end

    // Output register.
    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.finish) begin
            out_status <= res_status;
            out_row    <= draw_ok ? frow_reg : '0;
            out_col    <= draw_ok ? fcol_reg : '0;
            out_total  <= res_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_busy  = out_valid_reg && !out_ready;

    `GWD_ASSERT_NEXT(a_found_sticky, aclk, aresetn, rd_vld_reg && found_reg, found_reg, "found cell lost during scan")
    `GWD_ASSERT_NOW(a_draw_found, aclk, aresetn, cmd.finish && draw_ok, found_reg, "valid pick without a found cell")
    `GWD_ASSERT_NOW(a_write_in_area, aclk, aresetn, wr_en, wy_reg <= lastr && wx_reg <= lastc, "window write outside area")

endmodule

FILE: tb/sv/grid_weighted_draw_without_replacement_core_test.sv
// Self-checking testbench of the grid weighted draw core: random and directed items.
module grid_weighted_draw_without_replacement_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gwd_pkg::*;

    localparam int LIMIT_CYCLES = 6_000_000;
    localparam int SETTLE_CYCLES = 600;

    // Keeps its own copy of the grid and predicts the result of each item.
    class draw_scoreboard;
        logic [WGT_W-1:0] weights [CELLS];
        bit               drawn [CELLS];
        logic [4:0]       spread_x, spread_y;
        logic [3:0]       rows_cfg;
        logic [5:0]       cols_cfg;
        status_t          exp_status [$];
        logic [ROW_W-1:0] exp_row [$];
        logic [COL_W-1:0] exp_col [$];
        logic [TOT_W-1:0] exp_total [$];
        int               mismatches;

        function new();
            foreach (weights[k]) begin
                weights[k] = '0;
                drawn[k] = 0;
            end
            spread_x = 5'd16;
            spread_y = 5'd4;
            rows_cfg = 4'd8;
            cols_cfg = 6'd32;
            mismatches = 0;
        endfunction

        function int used_rows();
            if (rows_cfg == 0) return 1;
            if (rows_cfg > GRID_ROWS) return GRID_ROWS;
            return int'(rows_cfg);
        endfunction

        function int used_cols();
            if (cols_cfg == 0) return 1;
            if (cols_cfg > GRID_COLS) return GRID_COLS;
            return int'(cols_cfg);
        endfunction

        function int undrawn_sum();
            int sum;
            sum = 0;
            for (int r = 0; r < used_rows(); r++)
                for (int c = 0; c < used_cols(); c++)
                    if (!drawn[r * GRID_COLS + c]) sum += int'(weights[r * GRID_COLS + c]);
            return sum;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [5:0] value);
            case (idx)
                CFG_SPREAD_X: spread_x = value[4:0];
                CFG_SPREAD_Y: spread_y = value[4:0];
                CFG_ROWS:     rows_cfg = value[3:0];
                CFG_COLS:     cols_cfg = value;
            endcase
        endfunction

        function void note_input(logic [1:0] cmd, int row, int col, int pick);
            int sx, sy, cmin, cmax, rmin, rmax, w, total, run, sum;
            status_t st;
            int orow, ocol;
            bit found;
            st = STAT_DONE;
            orow = 0;
            ocol = 0;
            sx = int'(spread_x);
            sy = int'(spread_y);
            if (cmd == CMD_REGISTER) begin
                cmin = (col - sx < 0) ? 0 : col - sx;
                cmax = (col + sx > used_cols() - 1) ? used_cols() - 1 : col + sx;
                rmin = (row - sy < 0) ? 0 : row - sy;
                rmax = (row + sy > used_rows() - 1) ? used_rows() - 1 : row + sy;
                for (int y = rmin; y <= rmax; y++)
                    for (int x = cmin; x <= cmax; x++) begin
                        w = sx * sx + sy * sy - (x - col) * (x - col) - (y - row) * (y - row);
                        weights[y * GRID_COLS + x] = w[WGT_W-1:0];
                    end
            end else if (cmd == CMD_START) begin
                foreach (drawn[k]) drawn[k] = 0;
            end else if (cmd == CMD_DRAW) begin
                total = undrawn_sum();
                if (total == 0) begin
                    st = STAT_NO_WGT;
                end else if (pick == 0 || pick > total) begin
                    st = STAT_BAD_PICK;
                end else begin
                    st = STAT_DRAWN;
                    run = 0;
                    found = 0;
                    for (int r = 0; r < used_rows() && !found; r++)
                        for (int c = 0; c < used_cols() && !found; c++) begin
                            if (!drawn[r * GRID_COLS + c]) begin
                                run += int'(weights[r * GRID_COLS + c]);
                                if (run >= pick) begin
                                    drawn[r * GRID_COLS + c] = 1;
                                    orow = r;
                                    ocol = c;
                                    found = 1;
                                end
                            end
                        end
                end
            end
            sum = undrawn_sum();
            if (sum > 524287) sum = 524287;
            exp_status = {exp_status, st};
            exp_row = {exp_row, orow[ROW_W-1:0]};
            exp_col = {exp_col, ocol[COL_W-1:0]};
            exp_total = {exp_total, sum[TOT_W-1:0]};
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
            mismatches++;
        endtask

        task check_result(logic [1:0] st, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                          logic [TOT_W-1:0] total);
            if (exp_status.size() == 0) begin
                report_mismatch("unexpected result status", int'(st), -1);
            end else begin
                if (st !== exp_status[0]) report_mismatch("status", int'(st), int'(exp_status[0]));
                if (row !== exp_row[0]) report_mismatch("drawn_row", int'(row), int'(exp_row[0]));
                if (col !== exp_col[0]) report_mismatch("drawn_col", int'(col), int'(exp_col[0]));
                if (total !== exp_total[0])
                    report_mismatch("remaining_total", int'(total), int'(exp_total[0]));
                void'(exp_status.pop_front());
                void'(exp_row.pop_front());
                void'(exp_col.pop_front());
                void'(exp_total.pop_front());
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;

    draw_scoreboard grid_sb;
    bit  calm;
    int  stall_left;
    longint cycle_count;

    grid_weighted_draw_without_replacement_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial aclk = 0;
    always #10 aclk = ~aclk;

    // Mostly no gap, some short ones and now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready = 0;
        end else if (stall_left > 0) begin
            m_tready = 0;
            stall_left--;
        end else begin
            m_tready = 1;
            stall_left = gap_len();
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("grid_weighted_draw_without_replacement_core_test NOT OK");
            $finish;
        end
        if (aresetn && s_tvalid && s_tready)
            grid_sb.note_input(s_tuser, int'(s_tdata[2:0]), int'(s_tdata[7:3]),
                               int'(s_tdata[26:8]));
        if (aresetn && m_tvalid && m_tready)
            grid_sb.check_result(m_tuser, m_tdata[2:0], m_tdata[7:3], m_tdata[26:8]);
    end

    task send_item(logic [1:0] cmd, int row, int col, int pick);
        int gap;
        gap = gap_len();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 0;
        end
        @(negedge aclk);
        s_tvalid = 1;
        s_tuser = cmd;
        s_tdata = {5'd0, pick[PICK_W-1:0], col[COL_W-1:0], row[ROW_W-1:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    task wait_drained();
        @(negedge aclk);
        s_tvalid = 0;
        while (grid_sb.exp_status.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task write_reg(cfg_idx_t idx, int value);
        @(negedge aclk);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = value[5:0];
        do @(posedge aclk); while (!cfg_ready);
        grid_sb.set_reg(idx, value[5:0]);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    // A pick that is mostly valid for the total that is known right now.
    function automatic int draw_pick();
        int total, r;
        total = grid_sb.undrawn_sum();
        r = $urandom_range(0, 99);
        if (r < 5) return 0;
        if (r < 10) return $urandom_range(0, 524287);
        if (total == 0) return $urandom_range(1, 2000);
        if (r < 15) return total;
        return $urandom_range(1, total);
    endfunction

    task random_items(int count);
        int sent, n;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 15) begin
                send_item(2'($urandom_range(0, 3)), $urandom_range(0, 7),
                          $urandom_range(0, 31), $urandom_range(0, 524287));
                sent++;
            end else begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    send_item(CMD_REGISTER, $urandom_range(0, 7), $urandom_range(0, 31), 0);
                    sent++;
                end
                send_item(CMD_START, 0, 0, 0);
                sent++;
                n = $urandom_range(3, 25);
                repeat (n) begin
                    send_item(CMD_DRAW, 0, 0, draw_pick());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int sx_set [6] = '{0, 31, 16, 3, 1, 7};
        int sy_set [6] = '{0, 31, 4, 1, 2, 0};
        int rw_set [6] = '{8, 1, 0, 15, 3, 8};
        int cl_set [6] = '{32, 1, 0, 63, 5, 12};
        grid_sb = new();
        calm = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = CMD_REGISTER;
        cfg_valid = 0;
        cfg_index = CFG_SPREAD_X;
        cfg_data = '0;
        repeat (4) @(negedge aclk);
        aresetn = 1;

        // Directed part with the reset settings.
        send_item(CMD_DRAW, 0, 0, 1);
        send_item(2'd3, 7, 31, 524287);
        send_item(CMD_REGISTER, 0, 0, 0);
        send_item(CMD_REGISTER, 7, 31, 0);
        send_item(CMD_DRAW, 0, 0, 0);
        send_item(CMD_DRAW, 0, 0, 524287);
        send_item(CMD_DRAW, 0, 0, 1);
        // The sender holds off until every expected result has come.
        wait_drained();
        send_item(CMD_DRAW, 0, 0, grid_sb.undrawn_sum());
        send_item(CMD_REGISTER, 3, 16, 0);
        send_item(CMD_START, 0, 0, 0);
        send_item(CMD_DRAW, 0, 0, 1);
        send_item(CMD_REGISTER, 0, 0, 0);
        wait_drained();

        // A band outside a small area in use writes nothing.
        write_reg(CFG_ROWS, 2);
        write_reg(CFG_COLS, 4);
        write_reg(CFG_SPREAD_X, 1);
        write_reg(CFG_SPREAD_Y, 0);
        send_item(CMD_REGISTER, 7, 31, 0);
        send_item(CMD_REGISTER, 1, 5, 0);
        send_item(CMD_START, 0, 0, 0);
        repeat (6) send_item(CMD_DRAW, 0, 0, 1);
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            if (p < 6) begin
                write_reg(CFG_SPREAD_X, sx_set[p]);
                write_reg(CFG_SPREAD_Y, sy_set[p]);
                write_reg(CFG_ROWS, rw_set[p]);
                write_reg(CFG_COLS, cl_set[p]);
            end else begin
                write_reg(CFG_SPREAD_X, $urandom_range(0, 31));
                write_reg(CFG_SPREAD_Y, $urandom_range(0, 31));
                write_reg(CFG_ROWS, $urandom_range(0, 15));
                write_reg(CFG_COLS, $urandom_range(0, 63));
            end
            calm = (p % 4 == 3);
            random_items(112);
            wait_drained();
        end
        calm = 0;

        if (grid_sb.mismatches == 0 && grid_sb.exp_status.size() == 0) begin
            $display("grid_weighted_draw_without_replacement_core_test OK");
        end else begin
            $display("grid_weighted_draw_without_replacement_core_test NOT OK");
        end
        $finish;
    end
endmodule
